/* sv/tcp_flow_packet_tracker_top_defines.svh */
// assertion macros for the tcp flow packet tracker
`ifndef TCP_FLOW_PACKET_TRACKER_TOP_DEFINES_SVH
`define TCP_FLOW_PACKET_TRACKER_TOP_DEFINES_SVH

// implication checked on every rising clk edge outside reset
`define TFPT_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication checked in the cycle after the condition
`define TFPT_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/tfpt_pkg.sv */
// shared types and constants for the tcp flow packet tracker
package tfpt_pkg;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NON_HTTP_LIMIT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_MIN_PACKETS = 1'd1;

    localparam logic [7:0] NON_HTTP_LIMIT_RESET    = 8'd5;
    localparam logic [7:0] RESET_MIN_PACKETS_RESET = 8'd4;

    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

    localparam int unsigned FLAG_FIN_BIT = 0;
    localparam int unsigned FLAG_RST_BIT = 2;
    localparam int unsigned FLAG_ACK_BIT = 4;
    localparam logic [7:0]  FLAGS_SYN_ONLY = 8'h02;

    localparam logic [1:0] ACT_COUNTED  = 2'd0;
    localparam logic [1:0] ACT_STORED   = 2'd1;
    localparam logic [1:0] ACT_DROPPED  = 2'd2;
    localparam logic [1:0] ACT_FINISHED = 2'd3;

    typedef struct packed {
        logic [7:0] non_http_limit;
        logic [7:0] reset_min_packets;
    } cfg_t;

    typedef struct packed {
        logic        from_client;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] payload_length;
        logic [1:0]  http_kind;
        logic [31:0] capture_seconds;
        logic [19:0] capture_micros;
    } pkt_t;

    typedef struct packed {
        logic [31:0] round_trip_us;
        logic [31:0] client_packets;
        logic [31:0] server_packets;
        logic [31:0] client_bytes;
        logic [31:0] server_bytes;
        logic [31:0] syn_seconds;
        logic [19:0] syn_micros;
        logic        http_seen;
        logic [31:0] stored_client;
        logic [31:0] stored_server;
    } flow_state_t;

    typedef struct packed {
        logic [1:0]  action;
        flow_state_t flow;
    } result_t;

endpackage

/* sv/tfpt_in_stage.sv */
// input register stage holding one accepted packet header
module tfpt_in_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  tfpt_pkg::pkt_t in_pkt,
    input  logic          advance,
    output logic          held_valid,
    output tfpt_pkg::pkt_t held_pkt
);

    logic           valid_reg;
    logic           valid_next;
    tfpt_pkg::pkt_t pkt_reg;
    logic           load;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= in_pkt;
        end
    end

    assign held_valid = valid_reg;
    assign held_pkt   = pkt_reg;

endmodule

/* sv/tfpt_flow_core.sv */
// flow state registers and the per-packet update logic
module tfpt_flow_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  tfpt_pkg::pkt_t    pkt,
    input  tfpt_pkg::cfg_t    cfg,
    output tfpt_pkg::result_t result_next
);

    tfpt_pkg::flow_state_t state_reg;
    tfpt_pkg::flow_state_t state_next;
    tfpt_pkg::flow_state_t zero_state;
    tfpt_pkg::flow_state_t counted;
    tfpt_pkg::flow_state_t restarted;
    tfpt_pkg::flow_state_t shown;
    logic [1:0]            act;
    logic                  drop_limit;
    logic                  is_rst;
    logic                  is_fin;
    logic                  third_ack;
    logic                  is_http;
    logic [31:0]           sec_diff;
    logic [31:0]           usec_diff;
    logic [31:0]           rtt_value;

    function automatic tfpt_pkg::flow_state_t count_pkt(
        tfpt_pkg::flow_state_t s,
        logic                  cli,
        logic [15:0]           len
    );
        tfpt_pkg::flow_state_t r;
        r = s;
        if (cli)
        begin
            r.client_packets = s.client_packets + 32'd1;
            r.client_bytes   = s.client_bytes + {16'd0, len};
        end
        else
        begin
            r.server_packets = s.server_packets + 32'd1;
            r.server_bytes   = s.server_bytes + {16'd0, len};
        end
        return r;
    endfunction

    assign zero_state = '0;
    assign drop_limit = !state_reg.http_seen
                     && (state_reg.client_packets >= {24'd0, cfg.non_http_limit});
    assign is_rst     = pkt.tcp_flag_bits[tfpt_pkg::FLAG_RST_BIT];
    assign is_fin     = pkt.tcp_flag_bits[tfpt_pkg::FLAG_FIN_BIT];
    assign third_ack  = pkt.from_client && (state_reg.client_packets == 32'd1)
                     && pkt.tcp_flag_bits[tfpt_pkg::FLAG_ACK_BIT];
    assign is_http    = (pkt.http_kind != 2'd0);

    // handshake round trip, all modulo 2^32
    assign sec_diff  = pkt.capture_seconds - state_reg.syn_seconds;
    assign usec_diff = {12'd0, pkt.capture_micros} - {12'd0, state_reg.syn_micros};
    assign rtt_value = sec_diff * tfpt_pkg::USEC_PER_SEC + usec_diff;

    assign counted   = count_pkt(state_reg, pkt.from_client, pkt.payload_length);
    assign restarted = count_pkt(zero_state, pkt.from_client, pkt.payload_length);

    always_comb
    begin
        act        = tfpt_pkg::ACT_COUNTED;
        shown      = counted;
        state_next = counted;
        if (drop_limit)
        begin
            act        = tfpt_pkg::ACT_DROPPED;
            shown      = state_reg;
            state_next = zero_state;
        end
        else if (is_rst)
        begin
            if (state_reg.client_packets < {24'd0, cfg.reset_min_packets})
            begin
                act   = tfpt_pkg::ACT_DROPPED;
                shown = state_reg;
            end
            else
            begin
                act = tfpt_pkg::ACT_FINISHED;
            end
            state_next = zero_state;
        end
        else if (third_ack)
        begin
            shown.round_trip_us = rtt_value;
            state_next          = shown;
        end
        else if (is_fin)
        begin
            act        = tfpt_pkg::ACT_FINISHED;
            state_next = zero_state;
        end
        else if (pkt.from_client && (state_reg.client_packets == 32'd0))
        begin
            shown.syn_seconds = pkt.capture_seconds;
            shown.syn_micros  = pkt.capture_micros;
            state_next        = shown;
        end
        else if (pkt.from_client && (pkt.tcp_flag_bits == tfpt_pkg::FLAGS_SYN_ONLY))
        begin
            // repeated bare syn restarts the flow
            shown             = restarted;
            shown.syn_seconds = pkt.capture_seconds;
            shown.syn_micros  = pkt.capture_micros;
            state_next        = shown;
        end
        else if (is_http)
        begin
            act             = tfpt_pkg::ACT_STORED;
            shown.http_seen = 1'b1;
            if (pkt.from_client)
            begin
                shown.stored_client = state_reg.stored_client + 32'd1;
            end
            else
            begin
                shown.stored_server = state_reg.stored_server + 32'd1;
            end
            state_next = shown;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign result_next.action = act;
    assign result_next.flow   = shown;

endmodule

/* sv/tfpt_out_stage.sv */
// result register feeding the output channel
module tfpt_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tfpt_pkg::result_t result_in,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_stall,
    output tfpt_pkg::result_t result_out
);

    logic              valid_reg;
    logic              valid_next;
    tfpt_pkg::result_t result_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

/* sv/tcp_flow_packet_tracker_top.sv */
// Single-flow TCP packet tracker. Takes one packet header per cycle while in_stall is
// low and returns one result transaction per packet: the action (counted, counted and
// stored, dropped, finished) and the flow counters, SYN time, handshake RTT and HTTP
// bookkeeping as they stand after that packet, or for a dropped packet as they stood
// before it. A packet is registered on acceptance and, once the result register is free,
// updates the flow state and loads the result register, which offers its result. While
// out_stall holds a result, one more packet is taken and then in_stall rises until the
// result leaves. Configuration writes go through cfg_write, cfg_index and cfg_data and
// should be made only while no packet is in flight.
module tcp_flow_packet_tracker_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tfpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              from_client,
    input  logic [7:0]                        tcp_flag_bits,
    input  logic [15:0]                       payload_length,
    input  logic [1:0]                        http_kind,
    input  logic [31:0]                       capture_seconds,
    input  logic [19:0]                       capture_micros,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        action,
    output logic [31:0]                       round_trip_us,
    output logic [31:0]                       client_packets,
    output logic [31:0]                       server_packets,
    output logic [31:0]                       client_bytes,
    output logic [31:0]                       server_bytes,
    output logic [31:0]                       syn_seconds,
    output logic [19:0]                       syn_micros,
    output logic                              http_seen,
    output logic [31:0]                       stored_client,
    output logic [31:0]                       stored_server
);

    `include "tcp_flow_packet_tracker_top_defines.svh"

    tfpt_pkg::cfg_t    cfg_reg;
    tfpt_pkg::pkt_t    in_pkt;
    tfpt_pkg::pkt_t    held_pkt;
    tfpt_pkg::result_t result_next;
    tfpt_pkg::result_t result_q;
    logic              held_valid;
    logic              out_free;
    logic              advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.non_http_limit    <= tfpt_pkg::NON_HTTP_LIMIT_RESET;
            cfg_reg.reset_min_packets <= tfpt_pkg::RESET_MIN_PACKETS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                tfpt_pkg::CFG_NON_HTTP_LIMIT:    cfg_reg.non_http_limit    <= cfg_data;
                tfpt_pkg::CFG_RESET_MIN_PACKETS: cfg_reg.reset_min_packets <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_pkt.from_client     = from_client;
    assign in_pkt.tcp_flag_bits   = tcp_flag_bits;
    assign in_pkt.payload_length  = payload_length;
    assign in_pkt.http_kind       = http_kind;
    assign in_pkt.capture_seconds = capture_seconds;
    assign in_pkt.capture_micros  = capture_micros;

    assign advance = held_valid && out_free;

    tfpt_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_pkt     (in_pkt),
        .advance    (advance),
        .held_valid (held_valid),
        .held_pkt   (held_pkt)
    );

    tfpt_flow_core u_flow_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .pkt         (held_pkt),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    tfpt_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (result_next),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_q)
    );

    assign action         = result_q.action;
    assign round_trip_us  = result_q.flow.round_trip_us;
    assign client_packets = result_q.flow.client_packets;
    assign server_packets = result_q.flow.server_packets;
    assign client_bytes   = result_q.flow.client_bytes;
    assign server_bytes   = result_q.flow.server_bytes;
    assign syn_seconds    = result_q.flow.syn_seconds;
    assign syn_micros     = result_q.flow.syn_micros;
    assign http_seen      = result_q.flow.http_seen;
    assign stored_client  = result_q.flow.stored_client;
    assign stored_server  = result_q.flow.stored_server;

    // a held packet that cannot move keeps its slot and contents
    `TFPT_ASSERT_NEXT(a_held_pkt_kept, held_valid && !advance, held_valid && $stable(held_pkt), "held packet lost while blocked")

    // every processed packet produces a result transaction
    `TFPT_ASSERT_NEXT(a_advance_gives_result, advance, out_valid, "processed packet gave no result")

    // a stored result always comes with http marked and a stored count
    `TFPT_ASSERT_IMPL(a_stored_has_http, out_valid && (action == tfpt_pkg::ACT_STORED), http_seen && ((stored_client != 32'd0) || (stored_server != 32'd0)), "stored result without http bookkeeping")

endmodule

/* dv/tcp_flow_packet_tracker_checker.sv */
// checker for the tcp flow packet tracker: predicts each result transaction and compares it
module tcp_flow_packet_tracker_checker
    import tfpt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    from_client,
    input  logic [7:0]              tcp_flag_bits,
    input  logic [15:0]             payload_length,
    input  logic [1:0]              http_kind,
    input  logic [31:0]             capture_seconds,
    input  logic [19:0]             capture_micros,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [1:0]              action,
    input  logic [31:0]             round_trip_us,
    input  logic [31:0]             client_packets,
    input  logic [31:0]             server_packets,
    input  logic [31:0]             client_bytes,
    input  logic [31:0]             server_bytes,
    input  logic [31:0]             syn_seconds,
    input  logic [19:0]             syn_micros,
    input  logic                    http_seen,
    input  logic [31:0]             stored_client,
    input  logic [31:0]             stored_server,
    output int                      pending_results,
    output int                      checked_results,
    output int                      dropped_flows,
    output int                      finished_flows,
    output int                      stored_packets,
    output int                      error_count
);

    localparam int MAX_PRINTED = 40;

    flow_state_t flow_now;
    logic [7:0]  non_http_limit_q;
    logic [7:0]  reset_min_q;
    result_t     expected_results[$];
    pkt_t        in_pkt;
    result_t     out_res;
    result_t     want;

    int outstanding = 0;
    int checked     = 0;
    int drops       = 0;
    int finishes    = 0;
    int stores      = 0;
    int errors      = 0;

    assign in_pkt  = {from_client, tcp_flag_bits, payload_length, http_kind,
                      capture_seconds, capture_micros};
    assign out_res = {action, round_trip_us, client_packets, server_packets, client_bytes,
                      server_bytes, syn_seconds, syn_micros, http_seen, stored_client,
                      stored_server};

    assign pending_results = outstanding;
    assign checked_results = checked;
    assign dropped_flows   = drops;
    assign finished_flows  = finishes;
    assign stored_packets  = stores;
    assign error_count     = errors;

    task automatic report_mismatch(string msg);
        if (errors < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      checked, name, got, exp_val));
    endtask

    function automatic void tally_packet(logic cli, logic [15:0] len);
        if (cli)
        begin
            flow_now.client_packets += 32'd1;
            flow_now.client_bytes   += {16'd0, len};
        end
        else
        begin
            flow_now.server_packets += 32'd1;
            flow_now.server_bytes   += {16'd0, len};
        end
    endfunction

    // flow update for one packet; fields report the state before any clearing
    function automatic result_t track_packet(pkt_t p);
        result_t     r;
        logic [31:0] sec_diff;
        logic [31:0] usec_diff;
        r.action = ACT_COUNTED;
        r.flow   = '0;
        if (!flow_now.http_seen && flow_now.client_packets >= {24'd0, non_http_limit_q})
        begin
            r.action = ACT_DROPPED;
            r.flow   = flow_now;
            flow_now = '0;
            return r;
        end
        if (p.tcp_flag_bits[FLAG_RST_BIT])
        begin
            if (flow_now.client_packets < {24'd0, reset_min_q})
                r.action = ACT_DROPPED;
            else
            begin
                tally_packet(p.from_client, p.payload_length);
                r.action = ACT_FINISHED;
            end
            r.flow   = flow_now;
            flow_now = '0;
            return r;
        end
        if (p.from_client && flow_now.client_packets == 32'd1 && p.tcp_flag_bits[FLAG_ACK_BIT])
        begin
            // handshake ack closes the rtt measurement
            sec_diff  = p.capture_seconds - flow_now.syn_seconds;
            usec_diff = {12'd0, p.capture_micros} - {12'd0, flow_now.syn_micros};
            flow_now.round_trip_us = sec_diff * USEC_PER_SEC + usec_diff;
            tally_packet(p.from_client, p.payload_length);
        end
        else if (p.tcp_flag_bits[FLAG_FIN_BIT])
        begin
            tally_packet(p.from_client, p.payload_length);
            r.action = ACT_FINISHED;
            r.flow   = flow_now;
            flow_now = '0;
            return r;
        end
        else if (p.from_client &&
                 (flow_now.client_packets == 32'd0 || p.tcp_flag_bits == FLAGS_SYN_ONLY))
        begin
            // first client packet, or restart on a bare syn
            if (flow_now.client_packets != 32'd0)
                flow_now = '0;
            flow_now.syn_seconds = p.capture_seconds;
            flow_now.syn_micros  = p.capture_micros;
            tally_packet(p.from_client, p.payload_length);
        end
        else if (p.http_kind != 2'd0)
        begin
            flow_now.http_seen = 1'b1;
            if (p.from_client)
                flow_now.stored_client += 32'd1;
            else
                flow_now.stored_server += 32'd1;
            tally_packet(p.from_client, p.payload_length);
            r.action = ACT_STORED;
        end
        else
            tally_packet(p.from_client, p.payload_length);
        r.flow = flow_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_now         = '0;
            non_http_limit_q = NON_HTTP_LIMIT_RESET;
            reset_min_q      = RESET_MIN_PACKETS_RESET;
            expected_results.delete();
            outstanding      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transaction with no packet outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("action", {30'd0, out_res.action}, {30'd0, want.action});
                    check_field("round_trip_us", out_res.flow.round_trip_us,
                                want.flow.round_trip_us);
                    check_field("client_packets", out_res.flow.client_packets,
                                want.flow.client_packets);
                    check_field("server_packets", out_res.flow.server_packets,
                                want.flow.server_packets);
                    check_field("client_bytes", out_res.flow.client_bytes,
                                want.flow.client_bytes);
                    check_field("server_bytes", out_res.flow.server_bytes,
                                want.flow.server_bytes);
                    check_field("syn_seconds", out_res.flow.syn_seconds,
                                want.flow.syn_seconds);
                    check_field("syn_micros", {12'd0, out_res.flow.syn_micros},
                                {12'd0, want.flow.syn_micros});
                    check_field("http_seen", {31'd0, out_res.flow.http_seen},
                                {31'd0, want.flow.http_seen});
                    check_field("stored_client", out_res.flow.stored_client,
                                want.flow.stored_client);
                    check_field("stored_server", out_res.flow.stored_server,
                                want.flow.stored_server);
                    checked++;
                    if (want.action == ACT_DROPPED)
                        drops++;
                    if (want.action == ACT_FINISHED)
                        finishes++;
                    if (want.action == ACT_STORED)
                        stores++;
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(track_packet(in_pkt));
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NON_HTTP_LIMIT:    non_http_limit_q = cfg_data;
                    CFG_RESET_MIN_PACKETS: reset_min_q      = cfg_data;
                    default: ;
                endcase
            end
            outstanding = expected_results.size();
        end
    end

endmodule

/* dv/tcp_flow_packet_tracker_top_tb.sv */
// testbench top for the tcp flow packet tracker: clock, reset, packet and config stimulus, verdict
module tcp_flow_packet_tracker_top_tb;

    import tfpt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int N_PHASES      = 6;
    localparam int HOLD_PHASE    = 4;
    localparam int PHASE_PACKETS = 205;

    localparam logic [7:0] F_FIN   = 8'(1 << FLAG_FIN_BIT);
    localparam logic [7:0] F_RST   = 8'(1 << FLAG_RST_BIT);
    localparam logic [7:0] F_ACK   = 8'(1 << FLAG_ACK_BIT);
    localparam logic [7:0] F_PSH   = 8'h08;
    localparam logic [7:0] F_ALL   = 8'hFF;
    localparam logic [7:0] F_MIXED = 8'hEA;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_REQ  = 2'd1;
    localparam logic [1:0] KIND_RESP = 2'd2;
    localparam logic [1:0] KIND_ODD  = 2'd3;

    logic                   clk;
    logic                   rst_n           = 1'b0;
    logic                   cfg_write       = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index       = '0;
    logic [CFG_DATA_W-1:0]  cfg_data        = '0;
    logic                   in_valid        = 1'b0;
    logic                   in_stall;
    logic                   from_client     = 1'b0;
    logic [7:0]             tcp_flag_bits   = '0;
    logic [15:0]            payload_length  = '0;
    logic [1:0]             http_kind       = '0;
    logic [31:0]            capture_seconds = '0;
    logic [19:0]            capture_micros  = '0;
    logic                   out_valid;
    logic                   out_stall       = 1'b0;
    logic [1:0]             action;
    logic [31:0]            round_trip_us;
    logic [31:0]            client_packets;
    logic [31:0]            server_packets;
    logic [31:0]            client_bytes;
    logic [31:0]            server_bytes;
    logic [31:0]            syn_seconds;
    logic [19:0]            syn_micros;
    logic                   http_seen;
    logic [31:0]            stored_client;
    logic [31:0]            stored_server;

    int pending_results;
    int checked_results;
    int dropped_flows;
    int finished_flows;
    int stored_packets;
    int error_count;

    int   sent_packets = 0;
    int   cycle_count  = 0;
    logic no_idle      = 1'b0;
    logic hold_request = 1'b0;
    logic hold_active  = 1'b0;

    tcp_flow_packet_tracker_top u_top
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .from_client     (from_client),
        .tcp_flag_bits   (tcp_flag_bits),
        .payload_length  (payload_length),
        .http_kind       (http_kind),
        .capture_seconds (capture_seconds),
        .capture_micros  (capture_micros),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .round_trip_us   (round_trip_us),
        .client_packets  (client_packets),
        .server_packets  (server_packets),
        .client_bytes    (client_bytes),
        .server_bytes    (server_bytes),
        .syn_seconds     (syn_seconds),
        .syn_micros      (syn_micros),
        .http_seen       (http_seen),
        .stored_client   (stored_client),
        .stored_server   (stored_server)
    );

    tcp_flow_packet_tracker_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .from_client     (from_client),
        .tcp_flag_bits   (tcp_flag_bits),
        .payload_length  (payload_length),
        .http_kind       (http_kind),
        .capture_seconds (capture_seconds),
        .capture_micros  (capture_micros),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .round_trip_us   (round_trip_us),
        .client_packets  (client_packets),
        .server_packets  (server_packets),
        .client_bytes    (client_bytes),
        .server_bytes    (server_bytes),
        .syn_seconds     (syn_seconds),
        .syn_micros      (syn_micros),
        .http_seen       (http_seen),
        .stored_client   (stored_client),
        .stored_server   (stored_server),
        .pending_results (pending_results),
        .checked_results (checked_results),
        .dropped_flows   (dropped_flows),
        .finished_flows  (finished_flows),
        .stored_packets  (stored_packets),
        .error_count     (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results);
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [19:0] rand_micros();
        if ($urandom_range(0, 15) == 0)
            return 20'($urandom_range(0, 20'hFFFFF));
        return 20'($urandom_range(0, 999999));
    endfunction

    function automatic pkt_t make_pkt(logic cli, logic [7:0] flags, logic [15:0] len,
                                      logic [1:0] kind, logic [31:0] sec, logic [19:0] usec);
        return {cli, flags, len, kind, sec, usec};
    endfunction

    function automatic logic [15:0] phase_limits(int ph);
        case (ph)
            0:       return {8'd1, 8'd0};
            1:       return {8'd255, 8'd255};
            2:       return {8'd0, 8'd4};
            3:       return {8'd2, 8'd1};
            4:       return {8'd128, 8'd3};
            default: return {NON_HTTP_LIMIT_RESET, RESET_MIN_PACKETS_RESET};
        endcase
    endfunction

    // returns at the edge where the transaction was taken
    task automatic send_packet(pkt_t p);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        from_client     <= p.from_client;
        tcp_flag_bits   <= p.tcp_flag_bits;
        payload_length  <= p.payload_length;
        http_kind       <= p.http_kind;
        capture_seconds <= p.capture_seconds;
        capture_micros  <= p.capture_micros;
        do
            @(posedge clk);
        while (in_stall);
        sent_packets++;
    endtask

    task automatic wait_flow_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
    endtask

    task automatic set_limits(logic [7:0] limit, logic [7:0] min_pkts);
        wait_flow_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_NON_HTTP_LIMIT;
        cfg_data  <= limit;
        @(posedge clk);
        cfg_index <= CFG_RESET_MIN_PACKETS;
        cfg_data  <= min_pkts;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_flow();
        logic [31:0] base_sec;
        logic [7:0]  flags;
        int          body_len;
        int          ending;
        base_sec = $urandom();
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, base_sec, rand_micros()));
        send_packet(make_pkt(1'b0, FLAGS_SYN_ONLY | F_ACK, 16'd0, KIND_NONE, base_sec,
                             rand_micros()));
        send_packet(make_pkt(1'b1, F_ACK, 16'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             base_sec + $urandom_range(0, 2), rand_micros()));
        body_len = $urandom_range(0, 12);
        for (int i = 0; i < body_len; i++)
        begin
            flags = F_ACK;
            if ($urandom_range(0, 1) == 1)
                flags = flags | F_PSH;
            send_packet(make_pkt(1'($urandom_range(0, 1)), flags, 16'($urandom_range(0, 65535)),
                                 2'($urandom_range(0, 3)), base_sec + $urandom_range(0, 5),
                                 rand_micros()));
        end
        ending = $urandom_range(0, 9);
        // the remaining flows end on the next flow's bare syn
        if (ending < 5)
            send_packet(make_pkt(1'($urandom_range(0, 1)), F_FIN | F_ACK, 16'd0, KIND_NONE,
                                 base_sec + 6, rand_micros()));
        else if (ending < 7)
            send_packet(make_pkt(1'($urandom_range(0, 1)), F_RST | F_ACK, 16'd0, KIND_NONE,
                                 base_sec + 6, rand_micros()));
    endtask

    initial
    begin : receiver
        int stall_len;
        int open_len;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_len    = HOLD_CYCLES;
            end
            else if (no_idle || $urandom_range(0, 3) != 0)
                stall_len = 0;
            else
                stall_len = pick_gap();
            open_len = no_idle ? 1 : $urandom_range(1, 12);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                if (stall_len == HOLD_CYCLES)
                    hold_active = 1'b1;
                repeat (stall_len) @(posedge clk);
                hold_active = 1'b0;
            end
            out_stall <= 1'b0;
            repeat (open_len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] limits;
        int          phase_target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // normal http flow, closed by a server fin
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, 32'd100, 20'd999999));
        send_packet(make_pkt(1'b0, FLAGS_SYN_ONLY | F_ACK, 16'd0, KIND_NONE, 32'd100, 20'd5));
        send_packet(make_pkt(1'b1, F_ACK, 16'd0, KIND_NONE, 32'd101, 20'd0));
        send_packet(make_pkt(1'b1, F_ACK | F_PSH, 16'hFFFF, KIND_REQ, 32'd101, 20'd10));
        send_packet(make_pkt(1'b0, F_ACK, 16'd1200, KIND_RESP, 32'd101, 20'd20));
        send_packet(make_pkt(1'b1, F_ACK, 16'd0, KIND_ODD, 32'd101, 20'd30));
        send_packet(make_pkt(1'b0, F_FIN | F_ACK, 16'd0, KIND_NONE, 32'd102, 20'd0));
        // rtt across a seconds wrap with micros above range, then non-http drop
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, 32'hFFFFFFFF, 20'hFFFFF));
        send_packet(make_pkt(1'b1, F_ACK, 16'd1, KIND_NONE, 32'd0, 20'd0));
        send_packet(make_pkt(1'b1, 8'h00, 16'd7, KIND_NONE, 32'd0, 20'd1));
        send_packet(make_pkt(1'b1, F_ACK, 16'd0, KIND_NONE, 32'd0, 20'd2));
        send_packet(make_pkt(1'b1, F_ACK, 16'd0, KIND_NONE, 32'd0, 20'd3));
        send_packet(make_pkt(1'b0, F_ACK, 16'd0, KIND_NONE, 32'd0, 20'd4));
        // server speaks first, then early rst
        send_packet(make_pkt(1'b0, F_ACK, 16'd40, KIND_RESP, 32'd7, 20'd0));
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, 32'd8, 20'd0));
        send_packet(make_pkt(1'b1, F_RST, 16'd0, KIND_NONE, 32'd8, 20'd1));
        // restart on a repeated syn, then late rst with every flag set
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, 32'd9, 20'd500));
        send_packet(make_pkt(1'b1, F_ACK, 16'd3, KIND_REQ, 32'd9, 20'd900));
        send_packet(make_pkt(1'b1, FLAGS_SYN_ONLY, 16'd0, KIND_NONE, 32'd10, 20'd0));
        send_packet(make_pkt(1'b1, F_ACK, 16'd0, KIND_NONE, 32'd10, 20'd100));
        send_packet(make_pkt(1'b1, F_ACK, 16'd9, KIND_RESP, 32'd10, 20'd200));
        send_packet(make_pkt(1'b1, F_ACK, 16'd9, KIND_REQ, 32'd10, 20'd300));
        send_packet(make_pkt(1'b1, F_ALL, 16'hFFFF, KIND_ODD, 32'hFFFFFFFF, 20'hFFFFF));
        // first client packet carries http and odd flags, then client fin
        send_packet(make_pkt(1'b1, F_MIXED, 16'd0, KIND_REQ, 32'h5555AAAA, 20'hAAAAA));
        send_packet(make_pkt(1'b1, F_FIN, 16'd0, KIND_NONE, 32'hAAAA5555, 20'h55555));

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            limits = phase_limits(ph);
            set_limits(limits[15:8], limits[7:0]);
            no_idle      = (ph == N_PHASES - 1);
            phase_target = sent_packets + PHASE_PACKETS;
            if (ph == HOLD_PHASE)
            begin
                // receiver blocks while packets keep coming
                hold_request = 1'b1;
                wait (hold_active);
                send_random_flow();
                send_random_flow();
            end
            while (sent_packets < phase_target)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_packet(make_pkt(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                                         $urandom(), 20'($urandom_range(0, 20'hFFFFF))));
                else
                    send_random_flow();
            end
        end

        wait_flow_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d packets over %0d limit settings, extremes 0 and 255 on both registers",
                 sent_packets, N_PHASES + 1);
        $display("%0d results checked: %0d dropped, %0d finished, %0d stored, %0d mismatches",
                 checked_results, dropped_flows, finished_flows, stored_packets, error_count);
        if (error_count == 0 && pending_results == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
